>>> rtl/kpgas_pkg.sv
package kpgas_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    localparam logic [0:0] REG_COLUMN_SCALE = 1'd0;
    localparam logic [0:0] REG_ROW_SCALE    = 1'd1;

    localparam logic [15:0] SCALE_RESET = 16'd6554;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [11:0] radius;
    } t_in_item;

    typedef struct packed {
        logic [9:0] point_index;
        logic       found;
        logic       last;
        logic [1:0] status;
    } t_out_item;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL_X,
        DP_MUL_Y,
        DP_MUL_XLO,
        DP_MUL_XHI,
        DP_MUL_YLO,
        DP_MUL_YHI,
        DP_CELL_RD,
        DP_INSERT,
        DP_PUSH_FULL,
        DP_PUSH_ACK,
        DP_SWEEP,
        DP_SCAN_INIT,
        DP_PT_FIRST,
        DP_PT_NEXT,
        DP_TAKE,
        DP_SET_TRUNC,
        DP_ADVANCE,
        DP_PUSH_FINAL
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic count_full;
        logic sweep_done;
        logic cell_occ;
        logic match;
        logic is_last;
        logic n_full;
        logic pend_v;
        logic scan_empty;
        logic scan_done;
    } t_dp_status;

endpackage

>>> rtl/keypoint_grid_area_search.sv
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_stall    | i_in_data  (kpgas_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_stall  | o_out_data (kpgas_pkg::t_out_item)
// cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One item at a time. Clear: a sweep of the cell memory.
// Insert: two shared multiplier passes, one cell memory read-modify-write.
// Query: four multiplier passes, a walk of covered cells and points, a final result.
// After reset the cell memory is swept; no item is taken then.
// An output stall holds the sequencer only where a new result has to be written.
module keypoint_grid_area_search #(
    parameter int MAX_POINTS   = 1024,
    parameter int GRID_COLUMNS = 64,
    parameter int GRID_ROWS    = 48,
    parameter int MAX_MATCHES  = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  kpgas_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output kpgas_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    kpgas_pkg::t_dp_cmd    w_cmd;
    kpgas_pkg::t_dp_status w_status;

    kpgas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_data.cmd),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    kpgas_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS),
        .MAX_MATCHES  (MAX_MATCHES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/kpgas_dp.sv
module kpgas_dp #(
    parameter int MAX_POINTS   = 1024,
    parameter int GRID_COLUMNS = 64,
    parameter int GRID_ROWS    = 48,
    parameter int MAX_MATCHES  = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kpgas_pkg::t_dp_cmd   i_cmd,
    output kpgas_pkg::t_dp_status o_status,
    input  kpgas_pkg::t_in_item  i_in_data,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output kpgas_pkg::t_out_item o_out_data
);

    localparam int CELL_COUNT = GRID_COLUMNS * GRID_ROWS;
    localparam int PW  = $clog2(MAX_POINTS);
    localparam int CW  = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
    localparam int RW  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CAW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int NW  = $clog2(MAX_MATCHES + 1);
    localparam int CMW = 1 + 2 * PW;

    localparam logic [12:0] COL_LIM = 13'(GRID_COLUMNS - 1);
    localparam logic [12:0] ROW_LIM = 13'(GRID_ROWS - 1);

    logic [15:0] r_col_scale, r_row_scale;

    logic [15:0] r_px, r_py, r_r16;

    logic [32:0]             r_prod;
    kpgas_pkg::t_dp_op       r_mul_dst;
    logic [16:0]             n_mul_a;
    logic [15:0]             n_mul_b;
    logic [12:0]             w_cell_raw;

    logic [12:0]   r_minc, r_minr;
    logic [CW-1:0] r_maxc, r_col;
    logic [RW-1:0] r_maxr, r_row;

    logic [PW:0]      r_count;
    logic [CAW-1:0]   r_sweep;
    logic [PW-1:0]    r_idx;
    logic [NW-1:0]    r_n;
    logic             r_pend_v;
    logic [PW-1:0]    r_pend_idx;
    logic             r_trunc;

    logic             r_out_valid;
    kpgas_pkg::t_out_item r_out;
    logic             w_out_free;

    // cell word: occupied, first, last
    logic [CMW-1:0] r_cell_mem [CELL_COUNT];
    logic [CMW-1:0] r_cell_q;
    logic [31:0]    r_pt_mem [MAX_POINTS];
    logic [31:0]    r_pt_q;
    logic [PW-1:0]  r_next_mem [MAX_POINTS];
    logic [PW-1:0]  r_next_q;

    logic [CAW-1:0] w_cell_addr;
    logic           w_q_occ;
    logic [PW-1:0]  w_q_first, w_q_last;
    logic [15:0]    w_sx, w_sy, w_dx, w_dy;
    logic [PW-1:0]  w_new_idx;

    logic           n_cell_we;
    logic [CAW-1:0] n_cell_waddr;
    logic [CMW-1:0] n_cell_wdata;
    logic           n_pt_rd;
    logic [PW-1:0]  n_pt_raddr;

    assign w_cell_addr = CAW'(r_col) * CAW'(GRID_ROWS) + CAW'(r_row);
    assign w_q_occ     = r_cell_q[CMW-1];
    assign w_q_first   = r_cell_q[2*PW-1:PW];
    assign w_q_last    = r_cell_q[PW-1:0];
    assign w_sx        = r_pt_q[31:16];
    assign w_sy        = r_pt_q[15:0];
    assign w_dx        = (w_sx > r_px) ? w_sx - r_px : r_px - w_sx;
    assign w_dy        = (w_sy > r_py) ? w_sy - r_py : r_py - w_sy;
    assign w_new_idx   = r_count[PW-1:0];
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_cell_raw  = r_prod[32:20];

    always_comb begin
        n_mul_a = 17'(r_px);
        n_mul_b = r_col_scale;
        case (i_cmd.op)
            kpgas_pkg::DP_MUL_Y: begin
                n_mul_a = 17'(r_py);
                n_mul_b = r_row_scale;
            end
            kpgas_pkg::DP_MUL_XLO: n_mul_a = (r_px < r_r16) ? 17'd0 : 17'(r_px - r_r16);
            kpgas_pkg::DP_MUL_XHI: n_mul_a = 17'(r_px) + 17'(r_r16);
            kpgas_pkg::DP_MUL_YLO: begin
                n_mul_a = (r_py < r_r16) ? 17'd0 : 17'(r_py - r_r16);
                n_mul_b = r_row_scale;
            end
            kpgas_pkg::DP_MUL_YHI: begin
                n_mul_a = 17'(r_py) + 17'(r_r16);
                n_mul_b = r_row_scale;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_cell_we    = 1'b0;
        n_cell_waddr = w_cell_addr;
        n_cell_wdata = {1'b1, (w_q_occ ? w_q_first : w_new_idx), w_new_idx};
        if (i_cmd.op == kpgas_pkg::DP_SWEEP) begin
            n_cell_we    = 1'b1;
            n_cell_waddr = r_sweep;
            n_cell_wdata = '0;
        end else if (i_cmd.op == kpgas_pkg::DP_INSERT && w_out_free) begin
            n_cell_we = 1'b1;
        end
        n_pt_rd    = (i_cmd.op == kpgas_pkg::DP_PT_FIRST) || (i_cmd.op == kpgas_pkg::DP_PT_NEXT);
        n_pt_raddr = (i_cmd.op == kpgas_pkg::DP_PT_FIRST) ? w_q_first : r_next_q;
    end

    always_ff @(posedge i_clk) begin
        if (n_cell_we) begin
            r_cell_mem[n_cell_waddr] <= n_cell_wdata;
        end
        if (i_cmd.op == kpgas_pkg::DP_CELL_RD) begin
            r_cell_q <= r_cell_mem[w_cell_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == kpgas_pkg::DP_INSERT && w_out_free) begin
            r_pt_mem[w_new_idx] <= {r_px, r_py};
            if (w_q_occ) begin
                r_next_mem[w_q_last] <= w_new_idx;
            end
        end
        if (n_pt_rd) begin
            r_pt_q   <= r_pt_mem[n_pt_raddr];
            r_next_q <= r_next_mem[n_pt_raddr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= 33'(n_mul_a) * 33'(n_mul_b);
        case (r_mul_dst)
            kpgas_pkg::DP_MUL_X:   r_col  <= CW'((w_cell_raw > COL_LIM) ? COL_LIM : w_cell_raw);
            kpgas_pkg::DP_MUL_Y:   r_row  <= RW'((w_cell_raw > ROW_LIM) ? ROW_LIM : w_cell_raw);
            kpgas_pkg::DP_MUL_XLO: r_minc <= w_cell_raw;
            kpgas_pkg::DP_MUL_XHI: r_maxc <= CW'((w_cell_raw > COL_LIM) ? COL_LIM : w_cell_raw);
            kpgas_pkg::DP_MUL_YLO: r_minr <= w_cell_raw;
            kpgas_pkg::DP_MUL_YHI: r_maxr <= RW'((w_cell_raw > ROW_LIM) ? ROW_LIM : w_cell_raw);
            default: ;
        endcase
        unique case (i_cmd.op)
            kpgas_pkg::DP_LOAD: begin
                r_px  <= i_in_data.point_x;
                r_py  <= i_in_data.point_y;
                r_r16 <= {i_in_data.radius, 4'd0};
            end
            kpgas_pkg::DP_SCAN_INIT: begin
                r_col <= CW'(r_minc);
                r_row <= RW'(r_minr);
            end
            kpgas_pkg::DP_ADVANCE: begin
                if (r_row == r_maxr) begin
                    r_row <= RW'(r_minr);
                    r_col <= r_col + 1'b1;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end
            kpgas_pkg::DP_PT_FIRST: r_idx <= w_q_first;
            kpgas_pkg::DP_PT_NEXT:  r_idx <= r_next_q;
            kpgas_pkg::DP_TAKE:     r_pend_idx <= r_idx;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_scale <= kpgas_pkg::SCALE_RESET;
            r_row_scale <= kpgas_pkg::SCALE_RESET;
            r_mul_dst   <= kpgas_pkg::DP_NOP;
            r_count     <= '0;
            r_sweep     <= '0;
            r_n         <= '0;
            r_pend_v    <= 1'b0;
            r_trunc     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    kpgas_pkg::REG_COLUMN_SCALE: r_col_scale <= i_cfg_data;
                    kpgas_pkg::REG_ROW_SCALE:    r_row_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            r_mul_dst <= i_cmd.op;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                kpgas_pkg::DP_SWEEP: begin
                    r_count <= '0;
                    r_sweep <= (r_sweep == CAW'(CELL_COUNT - 1)) ? '0 : r_sweep + 1'b1;
                end
                kpgas_pkg::DP_INSERT: begin
                    if (w_out_free) begin
                        r_count     <= r_count + 1'b1;
                        r_out_valid <= 1'b1;
                        r_out       <= '{10'(w_new_idx), 1'b1, 1'b1, kpgas_pkg::ST_OK};
                    end
                end
                kpgas_pkg::DP_PUSH_FULL: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{10'd0, 1'b0, 1'b1, kpgas_pkg::ST_DROPPED};
                    end
                end
                kpgas_pkg::DP_PUSH_ACK: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{10'd0, 1'b0, 1'b1, kpgas_pkg::ST_OK};
                    end
                end
                kpgas_pkg::DP_SCAN_INIT: begin
                    r_n      <= '0;
                    r_pend_v <= 1'b0;
                    r_trunc  <= 1'b0;
                end
                kpgas_pkg::DP_TAKE: begin
                    // the held match is not the final one: send it on
                    if (r_pend_v) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{10'(r_pend_idx), 1'b1, 1'b0, kpgas_pkg::ST_OK};
                    end
                    r_pend_v <= 1'b1;
                    r_n      <= r_n + 1'b1;
                end
                kpgas_pkg::DP_SET_TRUNC: r_trunc <= 1'b1;
                kpgas_pkg::DP_PUSH_FINAL: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_pend_v) begin
                            r_out <= '{10'(r_pend_idx), 1'b1, 1'b1,
                                       (r_trunc ? kpgas_pkg::ST_TRUNC : kpgas_pkg::ST_OK)};
                        end else begin
                            r_out <= '{10'd0, 1'b0, 1'b1, kpgas_pkg::ST_OK};
                        end
                        r_pend_v <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_status.out_free   = w_out_free;
        o_status.count_full = (r_count >= (PW + 1)'(MAX_POINTS));
        o_status.sweep_done = (r_sweep == CAW'(CELL_COUNT - 1));
        o_status.cell_occ   = w_q_occ;
        o_status.match      = (w_dx < r_r16) && (w_dy < r_r16);
        o_status.is_last    = (r_idx == w_q_last);
        o_status.n_full     = (r_n == NW'(MAX_MATCHES));
        o_status.pend_v     = r_pend_v;
        o_status.scan_empty = (r_minc > 13'(r_maxc)) || (r_minr > 13'(r_maxr));
        o_status.scan_done  = (r_row == r_maxr) && (r_col == r_maxc);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/kpgas_ctrl.sv
module kpgas_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [1:0]            i_in_cmd,
    output logic                  o_in_stall,
    input  kpgas_pkg::t_dp_status i_status,
    output kpgas_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [22:0] {
        S_SWEEP_RST = 23'd1 << 0,
        S_IDLE      = 23'd1 << 1,
        S_SWEEP_CLR = 23'd1 << 2,
        S_ACK       = 23'd1 << 3,
        S_FULL      = 23'd1 << 4,
        S_INS_MX    = 23'd1 << 5,
        S_INS_MY    = 23'd1 << 6,
        S_INS_WAIT  = 23'd1 << 7,
        S_INS_RD    = 23'd1 << 8,
        S_INS_WR    = 23'd1 << 9,
        S_Q_M0      = 23'd1 << 10,
        S_Q_M1      = 23'd1 << 11,
        S_Q_M2      = 23'd1 << 12,
        S_Q_M3      = 23'd1 << 13,
        S_Q_WAIT    = 23'd1 << 14,
        S_Q_INIT    = 23'd1 << 15,
        S_Q_CELL    = 23'd1 << 16,
        S_Q_CHK     = 23'd1 << 17,
        S_Q_PT      = 23'd1 << 18,
        S_Q_NEXT    = 23'd1 << 19,
        S_FINAL     = 23'd1 << 20,
        S_Q_SPARE0  = 23'd1 << 21,
        S_Q_SPARE1  = 23'd1 << 22
    } t_state;

    t_state r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = kpgas_pkg::DP_NOP;
        unique case (r_state)
            S_SWEEP_RST, S_SWEEP_CLR: begin
                o_cmd.op = kpgas_pkg::DP_SWEEP;
                if (i_status.sweep_done) begin
                    n_state = (r_state == S_SWEEP_RST) ? S_IDLE : S_ACK;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = kpgas_pkg::DP_LOAD;
                    case (i_in_cmd)
                        kpgas_pkg::CMD_CLEAR:  n_state = S_SWEEP_CLR;
                        kpgas_pkg::CMD_INSERT: n_state = i_status.count_full ? S_FULL : S_INS_MX;
                        kpgas_pkg::CMD_QUERY:  n_state = S_Q_M0;
                        default:               n_state = S_ACK;
                    endcase
                end
            end
            S_ACK: begin
                o_cmd.op = kpgas_pkg::DP_PUSH_ACK;
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_FULL: begin
                o_cmd.op = kpgas_pkg::DP_PUSH_FULL;
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_INS_MX: begin
                o_cmd.op = kpgas_pkg::DP_MUL_X;
                n_state  = S_INS_MY;
            end
            S_INS_MY: begin
                o_cmd.op = kpgas_pkg::DP_MUL_Y;
                n_state  = S_INS_WAIT;
            end
            S_INS_WAIT: n_state = S_INS_RD;
            S_INS_RD: begin
                o_cmd.op = kpgas_pkg::DP_CELL_RD;
                n_state  = S_INS_WR;
            end
            S_INS_WR: begin
                o_cmd.op = kpgas_pkg::DP_INSERT;
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_Q_M0: begin
                o_cmd.op = kpgas_pkg::DP_MUL_XLO;
                n_state  = S_Q_M1;
            end
            S_Q_M1: begin
                o_cmd.op = kpgas_pkg::DP_MUL_XHI;
                n_state  = S_Q_M2;
            end
            S_Q_M2: begin
                o_cmd.op = kpgas_pkg::DP_MUL_YLO;
                n_state  = S_Q_M3;
            end
            S_Q_M3: begin
                o_cmd.op = kpgas_pkg::DP_MUL_YHI;
                n_state  = S_Q_WAIT;
            end
            S_Q_WAIT: n_state = S_Q_INIT;
            S_Q_INIT: begin
                o_cmd.op = kpgas_pkg::DP_SCAN_INIT;
                n_state  = i_status.scan_empty ? S_FINAL : S_Q_CELL;
            end
            S_Q_CELL: begin
                o_cmd.op = kpgas_pkg::DP_CELL_RD;
                n_state  = S_Q_CHK;
            end
            S_Q_CHK: begin
                if (i_status.cell_occ) begin
                    o_cmd.op = kpgas_pkg::DP_PT_FIRST;
                    n_state  = S_Q_PT;
                end else begin
                    o_cmd.op = kpgas_pkg::DP_ADVANCE;
                    n_state  = i_status.scan_done ? S_FINAL : S_Q_CELL;
                end
            end
            S_Q_PT: begin
                if (!i_status.match) begin
                    n_state = S_Q_NEXT;
                end else if (i_status.n_full) begin
                    o_cmd.op = kpgas_pkg::DP_SET_TRUNC;
                    n_state  = S_FINAL;
                end else if (!i_status.pend_v || i_status.out_free) begin
                    o_cmd.op = kpgas_pkg::DP_TAKE;
                    n_state  = S_Q_NEXT;
                end
            end
            S_Q_NEXT: begin
                if (i_status.is_last) begin
                    o_cmd.op = kpgas_pkg::DP_ADVANCE;
                    n_state  = i_status.scan_done ? S_FINAL : S_Q_CELL;
                end else begin
                    o_cmd.op = kpgas_pkg::DP_PT_NEXT;
                    n_state  = S_Q_PT;
                end
            end
            S_FINAL: begin
                o_cmd.op = kpgas_pkg::DP_PUSH_FINAL;
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP_RST;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
